@@ design/pdb_pkg.sv @@
// ----------------------------------------------------------------------------
// pdb_pkg
// Types, constants and saturation helpers shared by the dead-band PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdb_pkg;

  localparam logic [30:0] DT_DEFAULT   = 31'd655;
  localparam logic [30:0] IDT_DEFAULT  = 31'd6553600;
  localparam logic [30:0] OLIM_RESET   = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    REG_SETPOINT,
    REG_KP,
    REG_KI,
    REG_KD,
    REG_DT,
    REG_IDT,
    REG_OLIM,
    REG_DBAND
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_BAND,
    ST_INTEG,
    ST_PROP,
    ST_IGAIN,
    ST_DGAIN,
    ST_SUM,
    ST_WRITE
  } pdb_state_t;

  // effective register values (zero step sizes already replaced by defaults)
  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic [30:0]        dt;
    logic [30:0]        idt;
    logic [30:0]        olim;
    logic [30:0]        dband;
  } cfg_regs_t;

  function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] res;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      res = v[31:0];
    end else if (v[33]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp_mag(input logic signed [31:0] v,
                                                   input logic [30:0] lim);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [31:0] res;
    hi  = {1'b0, lim};
    lo  = -hi;
    res = v;
    if (v > hi) begin
      res = hi;
    end
    if (v < lo) begin
      res = lo;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/pdb_in_if.sv @@
// ----------------------------------------------------------------------------
// pdb_in_if
// Measurement word channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

`default_nettype wire

@@ design/pdb_out_if.sv @@
// ----------------------------------------------------------------------------
// pdb_out_if
// Drive word channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               in_dead_band;

  modport source (output valid, output drive, output in_dead_band, input ready);
  modport sink   (input valid, input drive, input in_dead_band, output ready);
endinterface

`default_nettype wire

@@ design/pdb_cfg_if.sv @@
// ----------------------------------------------------------------------------
// pdb_cfg_if
// Register write channel: index and data word, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdb_cfg_if
  import pdb_pkg::*;
;
  logic        valid;
  logic        ready;
  reg_idx_t    index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/pdb_cfg.sv @@
// ----------------------------------------------------------------------------
// pdb_cfg
// Configuration register file; substitutes defaults for zero step sizes.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_cfg
  import pdb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  pdb_cfg_if.sink     cfg_chan,
  output cfg_regs_t   cfg
);

  logic signed [31:0] setpoint_r;
  logic signed [31:0] kp_r;
  logic signed [31:0] ki_r;
  logic signed [31:0] kd_r;
  logic [30:0]        dt_r;
  logic [30:0]        idt_r;
  logic [30:0]        olim_r;
  logic [30:0]        dband_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= '0;
      kp_r       <= '0;
      ki_r       <= '0;
      kd_r       <= '0;
      dt_r       <= DT_DEFAULT;
      idt_r      <= IDT_DEFAULT;
      olim_r     <= OLIM_RESET;
      dband_r    <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_SETPOINT: setpoint_r <= cfg_chan.data;
        REG_KP:       kp_r       <= cfg_chan.data;
        REG_KI:       ki_r       <= cfg_chan.data;
        REG_KD:       kd_r       <= cfg_chan.data;
        REG_DT:       dt_r       <= cfg_chan.data[30:0];
        REG_IDT:      idt_r      <= cfg_chan.data[30:0];
        REG_OLIM:     olim_r     <= cfg_chan.data[30:0];
        REG_DBAND:    dband_r    <= cfg_chan.data[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.setpoint = setpoint_r;
    cfg.kp       = kp_r;
    cfg.ki       = ki_r;
    cfg.kd       = kd_r;
    cfg.dt       = (dt_r == '0) ? DT_DEFAULT : dt_r;
    cfg.idt      = (idt_r == '0) ? IDT_DEFAULT : idt_r;
    cfg.olim     = olim_r;
    cfg.dband    = dband_r;
  end

endmodule

`default_nettype wire

@@ design/pdb_mul.sv @@
// ----------------------------------------------------------------------------
// pdb_mul
// Shared Q16.16 multiplier: registered 64-bit product, floor shift by 16,
// saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_mul (
  input  wire logic                clk,
  input  wire logic signed [31:0]  op_a,
  input  wire logic signed [31:0]  op_b,
  output logic signed [31:0]       q
);

  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  always_comb begin
    if (prod_r[63:47] == '0 || prod_r[63:47] == '1) begin
      q = prod_r[47:16];
    end else if (prod_r[63]) begin
      q = 32'sh8000_0000;
    end else begin
      q = 32'sh7FFF_FFFF;
    end
  end

endmodule

`default_nettype wire

@@ design/pdb_core.sv @@
// ----------------------------------------------------------------------------
// pdb_core
// Sequencer and datapath: error, dead band test, integral, derivative and
// gain terms, all products through one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module pdb_core
  import pdb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  cfg_regs_t   cfg,
  pdb_in_if.sink      in_chan,
  pdb_out_if.source   out_chan
);

  pdb_state_t         state_r, state_nxt;
  logic signed [31:0] meas_r, meas_nxt;
  logic signed [31:0] err_r, err_nxt;
  logic signed [31:0] diff_r, diff_nxt;
  logic signed [31:0] prev_r, prev_nxt;
  logic signed [31:0] integ_r, integ_nxt;
  logic signed [31:0] deriv_r, deriv_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic               band_r, band_nxt;
  logic signed [31:0] drive_r, drive_nxt;
  logic               flag_r, flag_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] mul_q;
  logic               out_free;
  logic               in_fire;
  logic [31:0]        err_mag;
  logic               in_band;

  pdb_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .q    (mul_q)
  );

  assign out_free = !out_valid_r || out_chan.ready;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign err_mag  = err_r[31] ? (~err_r + 32'd1) : err_r;
  assign in_band  = err_mag <= {1'b0, cfg.dband};

  assign out_chan.valid        = out_valid_r;
  assign out_chan.drive        = drive_r;
  assign out_chan.in_dead_band = flag_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_chan.valid) state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_BAND;
      ST_BAND:  state_nxt = in_band ? ST_WRITE : ST_INTEG;
      ST_INTEG: state_nxt = ST_PROP;
      ST_PROP:  state_nxt = ST_IGAIN;
      ST_IGAIN: state_nxt = ST_DGAIN;
      ST_DGAIN: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_WRITE;
      ST_WRITE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // handshake and multiplier operand select
  always_comb begin
    in_chan.ready = (state_r == ST_IDLE);
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_BAND: begin
        mul_a = err_r;
        mul_b = {1'b0, cfg.dt};
      end
      ST_INTEG: begin
        mul_a = diff_r;
        mul_b = {1'b0, cfg.idt};
      end
      ST_PROP: begin
        mul_a = cfg.kp;
        mul_b = err_r;
      end
      ST_IGAIN: begin
        mul_a = cfg.ki;
        mul_b = integ_r;
      end
      ST_DGAIN: begin
        mul_a = cfg.kd;
        mul_b = deriv_r;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    meas_nxt      = meas_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    prev_nxt      = prev_r;
    integ_nxt     = integ_r;
    deriv_nxt     = deriv_r;
    acc_nxt       = acc_r;
    band_nxt      = band_r;
    drive_nxt     = drive_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      ST_IDLE:  if (in_fire) meas_nxt = in_chan.measurement;
      ST_ERR:   err_nxt = sat32(sx34(cfg.setpoint) - sx34(meas_r));
      ST_BAND: begin
        band_nxt = in_band;
        diff_nxt = sat32(sx34(err_r) - sx34(prev_r));
      end
      ST_INTEG: begin
        integ_nxt = clamp_mag(sat32(sx34(integ_r) + sx34(mul_q)), {1'b0, cfg.olim[30:1]});
      end
      ST_PROP:  deriv_nxt = mul_q;
      ST_IGAIN: acc_nxt = sx34(mul_q);
      ST_DGAIN: acc_nxt = acc_r + sx34(mul_q);
      ST_SUM:   acc_nxt = acc_r + sx34(mul_q);
      ST_WRITE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          flag_nxt      = band_r;
          if (band_r) begin
            drive_nxt = '0;
            prev_nxt  = '0;
            integ_nxt = '0;
          end else begin
            drive_nxt = -clamp_mag(sat32(acc_r), cfg.olim);
            prev_nxt  = err_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      integ_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      integ_r     <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r  <= meas_nxt;
    err_r   <= err_nxt;
    diff_r  <= diff_nxt;
    deriv_r <= deriv_nxt;
    acc_r   <= acc_nxt;
    band_r  <= band_nxt;
    drive_r <= drive_nxt;
    flag_r  <= flag_nxt;
  end

endmodule

`default_nettype wire

@@ design/pid_dead_band_controller.sv @@
// An accepted measurement is sequenced through five passes of the single
// shared 32x32 multiplier, then a sum and a write state; inside the dead band
// it goes from the band test straight to write. Write waits for the output
// channel; a new measurement is accepted only once the block is idle again.
// Reset (rst_n low, synchronous): registers to defaults, integral and previous
// error cleared, output channel empty.
// ----------------------------------------------------------------------------
// pid_dead_band_controller
// PID controller with dead band and integral anti-windup, signed Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_dead_band_controller
  import pdb_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  pdb_in_if.sink      in_chan,
  pdb_out_if.source   out_chan,
  pdb_cfg_if.sink     cfg_chan
);

  cfg_regs_t cfg_regs;

  pdb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg_regs)
  );

  pdb_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_regs),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

@@ tb/pid_dead_band_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_dead_band_controller_tb
// Drives measurement words through the dead-band PID block under random
// source gaps and sink stalls, across several register settings including
// the zero step, zero limit and full dead band corners. Every drive word is
// compared against a cycle-free Q16.16 model of the controller or against an expected value given with the stimulus.
// ----------------------------------------------------------------------------

module pid_dead_band_controller_tb;
  import pdb_pkg::*;

  localparam int     CYCLE_LIMIT   = 200000;
  localparam int     PHASES        = 10;
  localparam int     WORDS_PER_SET = 53;
  localparam longint MAX32         = 64'sd2147483647;
  localparam longint MIN32         = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] drive;
    logic               in_band;
  } drive_word_t;

  typedef struct {
    bit          is_write;
    reg_idx_t    idx;
    logic [31:0] data;
    logic [31:0] meas;
    bit          typed;
    logic [31:0] want_drive;
    bit          want_band;
  } stim_row_t;

  logic clk;
  logic rst_n;

  pdb_in_if  in_if();
  pdb_out_if out_if();
  pdb_cfg_if cfg_if();

  pid_dead_band_controller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // controller model: registers and loop state
  logic signed [31:0] m_setpoint;
  logic signed [31:0] m_kp;
  logic signed [31:0] m_ki;
  logic signed [31:0] m_kd;
  logic [30:0]        m_dt;
  logic [30:0]        m_idt;
  logic [30:0]        m_olim;
  logic [30:0]        m_dband;
  logic signed [31:0] m_prev_err;
  logic signed [31:0] m_integral;

  drive_word_t pending_drive[$];
  stim_row_t   stim_rows[$];

  int  mismatches;
  int  words_sent;
  int  words_checked;
  int  reg_writes;
  int  settings_seen;
  int  cycle_count = 0;
  bit  quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, pending_drive.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] clip32(input longint v);
    logic signed [31:0] r;
    if (v > MAX32) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < MIN32) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q16.16 product, floor rounding, saturated
  function automatic logic signed [31:0] qmul16(input logic signed [31:0] a, input longint b);
    longint p;
    p = longint'(a) * b;
    return clip32(p >>> 16);
  endfunction

  task automatic model_reset();
    m_setpoint = '0;
    m_kp       = '0;
    m_ki       = '0;
    m_kd       = '0;
    m_dt       = DT_DEFAULT;
    m_idt      = IDT_DEFAULT;
    m_olim     = OLIM_RESET;
    m_dband    = '0;
    m_prev_err = '0;
    m_integral = '0;
  endtask

  task automatic model_write(input reg_idx_t idx, input logic [31:0] data);
    case (idx)
      REG_SETPOINT: m_setpoint = data;
      REG_KP:       m_kp       = data;
      REG_KI:       m_ki       = data;
      REG_KD:       m_kd       = data;
      REG_DT:       m_dt       = data[30:0];
      REG_IDT:      m_idt      = data[30:0];
      REG_OLIM:     m_olim     = data[30:0];
      REG_DBAND:    m_dband    = data[30:0];
      default: ;
    endcase
  endtask

  function automatic drive_word_t control_step(input logic signed [31:0] meas);
    drive_word_t        w;
    logic signed [31:0] err;
    logic signed [31:0] integ;
    logic signed [31:0] diff;
    logic signed [31:0] deriv;
    logic signed [31:0] out_val;
    logic [30:0]        dt_eff;
    logic [30:0]        idt_eff;
    longint             mag;
    longint             ilim;
    longint             olim;
    longint             sum;
    err     = clip32(longint'(m_setpoint) - longint'(meas));
    mag     = (err < 0) ? -longint'(err) : longint'(err);
    dt_eff  = (m_dt == '0) ? DT_DEFAULT : m_dt;
    idt_eff = (m_idt == '0) ? IDT_DEFAULT : m_idt;
    if (mag <= longint'({1'b0, m_dband})) begin
      m_integral = '0;
      m_prev_err = '0;
      w.drive    = '0;
      w.in_band  = 1'b1;
      return w;
    end
    integ = clip32(longint'(m_integral) + longint'(qmul16(err, longint'({1'b0, dt_eff}))));
    ilim  = longint'({1'b0, m_olim >> 1});
    if (longint'(integ) > ilim) integ = ilim[31:0];
    if (longint'(integ) < -ilim) integ = 32'(-ilim);
    m_integral = integ;
    diff  = clip32(longint'(err) - longint'(m_prev_err));
    deriv = qmul16(diff, longint'({1'b0, idt_eff}));
    sum   = longint'(qmul16(m_kp, longint'(err)))
          + longint'(qmul16(m_ki, longint'(integ)))
          + longint'(qmul16(m_kd, longint'(deriv)));
    out_val    = clip32(sum);
    m_prev_err = err;
    olim = longint'({1'b0, m_olim});
    if (longint'(out_val) > olim) out_val = olim[31:0];
    if (longint'(out_val) < -olim) out_val = 32'(-olim);
    w.drive   = -out_val;
    w.in_band = 1'b0;
    return w;
  endfunction

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // sink: random stall per word, check on acceptance
  initial begin
    int          stall;
    drive_word_t want;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      words_checked++;
      if (pending_drive.size() == 0) begin
        report($sformatf("unexpected drive word %h", out_if.drive));
      end else begin
        want = pending_drive.pop_front();
        if (out_if.drive !== want.drive) begin
          report($sformatf("drive %h, want %h", out_if.drive, want.drive));
        end
        if (out_if.in_dead_band !== want.in_band) begin
          report($sformatf("in_dead_band %b, want %b", out_if.in_dead_band, want.in_band));
        end
      end
      @(negedge clk);
    end
  end

  // returns at the falling edge after acceptance with valid still high
  task automatic send_word(input logic [31:0] meas, input bit typed,
                           input logic [31:0] want_drive, input bit want_band);
    int          gap;
    drive_word_t w;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.measurement <= meas;
    in_if.valid       <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    w = control_step(meas);
    if (typed) begin
      w.drive   = want_drive;
      w.in_band = want_band;
    end
    pending_drive.push_back(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    model_write(idx, data);
    reg_writes++;
    @(negedge clk);
  endtask

  // hold the source until every drive word is back, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending_drive.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic add_write(input reg_idx_t idx, input logic [31:0] data);
    stim_rows.push_back('{1'b1, idx, data, 32'h0, 1'b0, 32'h0, 1'b0});
  endtask

  task automatic add_meas(input logic [31:0] meas);
    stim_rows.push_back('{1'b0, REG_SETPOINT, 32'h0, meas, 1'b0, 32'h0, 1'b0});
  endtask

  task automatic add_typed(input logic [31:0] meas, input logic [31:0] d, input bit b);
    stim_rows.push_back('{1'b0, REG_SETPOINT, 32'h0, meas, 1'b1, d, b});
  endtask

  task automatic build_rows();
    // reset settings: zero gains, so any word outside the band drives zero
    add_typed(32'h0000_0000, 32'h0, 1'b1);
    add_typed(32'h8000_0000, 32'h0, 1'b0);
    add_typed(32'h7FFF_FFFF, 32'h0, 1'b0);
    add_typed(32'h0000_0001, 32'h0, 1'b0);
    // moderate gains, band edge at exactly 1.0
    add_write(REG_KP,    32'h0001_0000);
    add_write(REG_KI,    32'h0000_8000);
    add_write(REG_KD,    32'h0000_0100);
    add_write(REG_DBAND, 32'h0001_0000);
    add_typed(32'h0001_0000, 32'h0, 1'b1);
    add_meas (32'h0001_0001);
    add_typed(32'hFFFF_0000, 32'h0, 1'b1);
    add_meas (32'h0005_0000);
    add_meas (32'hFFFD_0000);
    // extreme gains, zero step sizes fall back to defaults, top data bit ignored
    add_write(REG_KP,       32'h7FFF_FFFF);
    add_write(REG_KI,       32'h8000_0000);
    add_write(REG_KD,       32'h7FFF_FFFF);
    add_write(REG_SETPOINT, 32'h7FFF_FFFF);
    add_write(REG_DT,       32'h8000_0000);
    add_write(REG_IDT,      32'h0000_0000);
    add_write(REG_OLIM,     32'h0010_0000);
    add_write(REG_DBAND,    32'h8000_0000);
    add_meas (32'h8000_0000);
    add_typed(32'h7FFF_FFFF, 32'h0, 1'b1);
    add_meas (32'h0000_0000);
    add_meas (32'h8000_0000);
    // zero output limit forces drive to zero
    add_write(REG_OLIM, 32'h0000_0000);
    add_typed(32'h0000_0000, 32'h0, 1'b0);
    add_typed(32'h1234_5678, 32'h0, 1'b0);
    // full-scale band, steps and limit
    add_write(REG_SETPOINT, 32'h8000_0000);
    add_write(REG_OLIM,     32'h7FFF_FFFF);
    add_write(REG_DT,       32'h7FFF_FFFF);
    add_write(REG_IDT,      32'hFFFF_FFFF);
    add_write(REG_DBAND,    32'h7FFF_FFFF);
    add_meas (32'h0000_0000);
    add_meas (32'h7FFF_FFFF);
    add_typed(32'h8000_0000, 32'h0, 1'b1);
    add_meas (32'h0000_0001);
    // negative proportional and derivative gains around zero
    add_write(REG_DBAND,    32'h0000_0000);
    add_write(REG_KP,       32'hFFFF_0000);
    add_write(REG_KI,       32'h0001_0000);
    add_write(REG_KD,       32'hFFFF_FF00);
    add_write(REG_SETPOINT, 32'h0000_0000);
    add_write(REG_DT,       32'h0000_028F);
    add_write(REG_IDT,      32'h0064_0000);
    add_meas (32'h0000_1000);
    add_meas (32'hFFFF_F000);
    add_meas (32'h0040_0000);
  endtask

  function automatic logic [31:0] pick_gain();
    logic [31:0] r;
    case ($urandom_range(0, 9))
      0: r = 32'h7FFF_FFFF;
      1: r = 32'h8000_0000;
      2: r = 32'h0;
      default: r = $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
    endcase
    return r;
  endfunction

  function automatic logic [30:0] pick_field(input reg_idx_t idx);
    logic [30:0] v;
    int          sel;
    sel = $urandom_range(0, 11);
    if (sel == 0) begin
      v = '0;
    end else if (sel == 1) begin
      v = 31'h7FFF_FFFF;
    end else begin
      case (idx)
        REG_DT:    v = 31'($urandom_range(1, 32'h0000_8000));
        REG_IDT:   v = 31'($urandom_range(1, 32'h0064_0000));
        REG_OLIM:  v = 31'($urandom_range(32'h0000_1000, 32'h0200_0000));
        default:   v = 31'($urandom_range(0, 32'h0002_0000));
      endcase
    end
    return v;
  endfunction

  function automatic logic [31:0] pick_meas();
    logic [31:0] m;
    longint      spread;
    longint      offset;
    case ($urandom_range(0, 9))
      0: m = $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: m = 32'h8000_0000;
          1: m = 32'h7FFF_FFFF;
          2: m = 32'h0;
          default: m = m_setpoint;
        endcase
      end
      default: begin
        spread = longint'({1'b0, m_dband}) + 64'sh8000;
        if (spread > 64'sh40_0000) spread = 64'sh40_0000;
        offset = longint'($urandom_range(0, 32'(2 * spread))) - spread;
        m = 32'(longint'(m_setpoint) + offset);
      end
    endcase
    return m;
  endfunction

  initial begin
    stim_row_t   row;
    bit          writing;
    logic [31:0] sp;
    in_if.valid       = 1'b0;
    in_if.measurement = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_SETPOINT;
    cfg_if.data       = '0;
    rst_n             = 1'b0;
    mismatches        = 0;
    words_sent        = 0;
    words_checked     = 0;
    reg_writes        = 0;
    settings_seen     = 1;
    quiet             = 1'b0;
    writing           = 1'b0;
    model_reset();
    build_rows();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_write) begin
        if (!writing) begin
          drain();
          writing = 1'b1;
          settings_seen++;
        end
        write_reg(row.idx, row.data);
      end else begin
        if (writing) begin
          cfg_if.valid <= 1'b0;
          writing = 1'b0;
        end
        send_word(row.meas, row.typed, row.want_drive, row.want_band);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      settings_seen++;
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0: sp = $urandom;
        1: sp = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: sp = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
      write_reg(REG_SETPOINT, sp);
      write_reg(REG_KP,    pick_gain());
      write_reg(REG_KI,    pick_gain());
      write_reg(REG_KD,    pick_gain());
      write_reg(REG_DT,    {1'($urandom_range(0, 1)), pick_field(REG_DT)});
      write_reg(REG_IDT,   {1'($urandom_range(0, 1)), pick_field(REG_IDT)});
      write_reg(REG_OLIM,  {1'($urandom_range(0, 1)), pick_field(REG_OLIM)});
      write_reg(REG_DBAND, {1'($urandom_range(0, 1)), pick_field(REG_DBAND)});
      cfg_if.valid <= 1'b0;
      for (int k = 0; k < WORDS_PER_SET; k++) begin
        if (p == 4 && k == WORDS_PER_SET / 2) drain();
        send_word(pick_meas(), 1'b0, 32'h0, 1'b0);
      end
    end

    drain();
    repeat (20) @(negedge clk);
    $display("Sent %0d measurement words over %0d register settings (%0d writes);",
             words_sent, settings_seen, reg_writes);
    $display("checked %0d drive words with %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
